/* sv/cct_pkg.sv */
// Package for the calendar clock tick core: beat types, calendar state type, constants.
`default_nettype none
package cct_pkg;

   // Field limits
   localparam logic [6:0] SecondMax  = 7'd59;
   localparam logic [6:0] MinuteMax  = 7'd59;
   localparam logic [5:0] HourMax    = 6'd23;
   localparam logic [3:0] WeekdayMax = 4'd6;
   localparam logic [4:0] MonthMax   = 5'd12;
   localparam logic [4:0] DaysLong   = 5'd31;
   localparam logic [4:0] DaysShort  = 5'd30;
   localparam logic [4:0] DaysFeb    = 5'd28;
   localparam logic [4:0] DaysLeap   = 5'd29;

   // Command codes
   localparam logic CmdTick = 1'b0;
   localparam logic CmdLoad = 1'b1;

   // Changed-mask bits
   localparam logic [5:0] MaskSecond = 6'h01;
   localparam logic [5:0] MaskMinute = 6'h02;
   localparam logic [5:0] MaskHour   = 6'h04;
   localparam logic [5:0] MaskDay    = 6'h08;
   localparam logic [5:0] MaskMonth  = 6'h10;
   localparam logic [5:0] MaskYear   = 6'h20;
   localparam logic [5:0] MaskAll    = 6'h3F;

   // Month codes
   localparam logic [3:0] MonJan = 4'd1;
   localparam logic [3:0] MonMar = 4'd3;
   localparam logic [3:0] MonApr = 4'd4;
   localparam logic [3:0] MonMay = 4'd5;
   localparam logic [3:0] MonJun = 4'd6;
   localparam logic [3:0] MonJul = 4'd7;
   localparam logic [3:0] MonAug = 4'd8;
   localparam logic [3:0] MonSep = 4'd9;
   localparam logic [3:0] MonOct = 4'd10;
   localparam logic [3:0] MonNov = 4'd11;
   localparam logic [3:0] MonDec = 4'd12;

   typedef struct packed {
      logic        cmd;
      logic [5:0]  load_second;
      logic [5:0]  load_minute;
      logic [4:0]  load_hour;
      logic [4:0]  load_day;
      logic [3:0]  load_month;
      logic [15:0] load_year;
      logic [2:0]  load_weekday;
   } req_type;

   typedef struct packed {
      logic [5:0]  second;
      logic [5:0]  minute;
      logic [4:0]  hour;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [15:0] year;
      logic [2:0]  weekday;
      logic [5:0]  changed_mask;
   } rsp_type;

   typedef struct packed {
      logic [5:0]  second;
      logic [5:0]  minute;
      logic [4:0]  hour;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [15:0] year;
      logic [2:0]  weekday;
   } cal_type;

   // Days in a month; unknown month codes fall back to February rules
   function automatic logic [4:0] month_length(input logic [3:0] mon, input logic [1:0] yr_lo);
      logic [4:0] len;
      case (mon)
         MonJan, MonMar, MonMay, MonJul, MonAug, MonOct, MonDec: len = DaysLong;
         MonApr, MonJun, MonSep, MonNov:                         len = DaysShort;
         default:                                                len = (yr_lo == 2'd0) ? DaysLeap
                                                                                       : DaysFeb;
      endcase
      return len;
   endfunction

endpackage
`default_nettype wire

/* sv/cct_step.sv */
// Next calendar state and changed mask for one tick or load beat.
`default_nettype none
module cct_step (
   input  var cct_pkg::cal_type cur,
   input  var cct_pkg::req_type req,
   output cct_pkg::cal_type     nxt,
   output logic [5:0]           mask
);
   import cct_pkg::*;

   logic [6:0]  sec_inc;
   logic [6:0]  min_inc;
   logic [5:0]  hour_inc;
   logic [3:0]  wday_inc;
   logic [5:0]  day_inc;
   logic [4:0]  mon_inc;
   logic [4:0]  mon_len;
   logic        sec_wrap, min_wrap, hour_wrap, day_wrap, mon_wrap;
   cal_type     tick_cal;
   logic [5:0]  tick_mask;

   // Per-field increments and rollover tests
   assign sec_inc   = {1'b0, cur.second} + 7'd1;
   assign min_inc   = {1'b0, cur.minute} + 7'd1;
   assign hour_inc  = {1'b0, cur.hour} + 6'd1;
   assign wday_inc  = {1'b0, cur.weekday} + 4'd1;
   assign day_inc   = {1'b0, cur.day} + 6'd1;
   assign mon_inc   = {1'b0, cur.month} + 5'd1;
   assign mon_len   = month_length(cur.month, cur.year[1:0]);
   assign sec_wrap  = sec_inc > SecondMax;
   assign min_wrap  = min_inc > MinuteMax;
   assign hour_wrap = hour_inc > HourMax;
   assign day_wrap  = day_inc > {1'b0, mon_len};
   assign mon_wrap  = mon_inc > MonthMax;

   // Carry cascade
   always_comb begin
      tick_cal  = cur;
      tick_mask = MaskSecond;
      tick_cal.second = sec_wrap ? 6'd0 : sec_inc[5:0];
      if (sec_wrap) begin
         tick_mask |= MaskMinute;
         tick_cal.minute = min_wrap ? 6'd0 : min_inc[5:0];
         if (min_wrap) begin
            tick_mask |= MaskHour;
            tick_cal.hour = hour_wrap ? 5'd0 : hour_inc[4:0];
            if (hour_wrap) begin
               tick_mask |= MaskDay;
               tick_cal.weekday = (wday_inc > WeekdayMax) ? 3'd0 : wday_inc[2:0];
               tick_cal.day     = day_wrap ? 5'd1 : day_inc[4:0];
               if (day_wrap) begin
                  tick_mask |= MaskMonth;
                  tick_cal.month = mon_wrap ? 4'd1 : mon_inc[3:0];
                  if (mon_wrap) begin
                     tick_mask |= MaskYear;
                     tick_cal.year = cur.year + 16'd1;
                  end
               end
            end
         end
      end
   end

   // Load overrides tick
   always_comb begin
      case (req.cmd)
         CmdLoad: begin
            nxt.second  = req.load_second;
            nxt.minute  = req.load_minute;
            nxt.hour    = req.load_hour;
            nxt.day     = req.load_day;
            nxt.month   = req.load_month;
            nxt.year    = req.load_year;
            nxt.weekday = req.load_weekday;
            mask        = MaskAll;
         end
         default: begin
            nxt  = tick_cal;
            mask = tick_mask;
         end
      endcase
   end

endmodule
`default_nettype wire

/* sv/calendar_clock_tick_core.sv */
// A request beat is registered, then its response is registered once the output stage is free.
// One beat per cycle unless the response stalls; the calendar update is a single carry cascade.
// A stalled response holds in the output register while the input register still fills.
// Reset (synchronous, active high) sets 00:00:00, day 1, month 1, year 0, weekday 0,
// and empties both stages.
`default_nettype none
module calendar_clock_tick_core (
   input  var logic             clock,
   input  var logic             reset,
   input  var logic             req_valid,
   output logic                 req_ready,
   input  var cct_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  var logic             rsp_ready,
   output cct_pkg::rsp_type     rsp_data
);
   import cct_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   cal_type cal_ff, cal_in;
   logic [5:0] step_mask;
   logic    out_free, step_fire;

   // Pipeline flow control
   assign out_free  = !out_valid_ff || rsp_ready;
   assign step_fire = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign in_valid_in  = req_ready ? req_valid : in_valid_ff;
   assign out_valid_in = out_free ? in_valid_ff : out_valid_ff;

   cct_step u_step (
      .cur  (cal_ff),
      .req  (in_data_ff),
      .nxt  (cal_in),
      .mask (step_mask)
   );

   // Control and calendar state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         cal_ff       <= '{second: 6'd0, minute: 6'd0, hour: 5'd0, day: 5'd1,
                           month: 4'd1, year: 16'd0, weekday: 3'd0};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (step_fire) begin
            cal_ff <= cal_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (step_fire) begin
         out_data_ff <= '{second: cal_in.second, minute: cal_in.minute, hour: cal_in.hour,
                          day: cal_in.day, month: cal_in.month, year: cal_in.year,
                          weekday: cal_in.weekday, changed_mask: step_mask};
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule
`default_nettype wire
